FILE: hdl/cpvp_pkg.sv
// Shared types, constants and helper functions of the cascaded position/velocity controller.
`default_nettype none

package cpvp_pkg;

    // Sine/cosine table of half angles.
    localparam int TRIG_DEPTH = 64;
    localparam int TRIG_LAST  = (TRIG_DEPTH > 1) ? TRIG_DEPTH - 1 : 1;
    localparam int TRIG_KW    = $clog2(TRIG_DEPTH);
    localparam int TRIG_DCW   = (TRIG_KW > 1) ? $clog2(TRIG_KW) : 1;
    localparam int TRIG_NW    = 14 + TRIG_KW + 1;

    // Digit-serial multiplier geometry.
    localparam int MUL_AW   = 33;
    localparam int MUL_BW   = 17;
    localparam int MUL_PW   = MUL_AW + MUL_BW;
    localparam int MUL_DIG  = 4;
    localparam int MUL_NDIG = (MUL_BW - 1) / MUL_DIG;
    localparam int MUL_CW   = $clog2(MUL_NDIG + 1);

    // Register reset values.
    localparam logic signed [31:0] RST_TARGET_X   = 32'sd196608;
    localparam logic signed [31:0] RST_TARGET_Y   = 32'sd65536;
    localparam logic signed [31:0] RST_TARGET_Z   = 32'sd131072;
    localparam logic [63:0]        RST_OUTER      = 64'd23103819327996096;
    localparam logic [63:0]        RST_INNER      = 64'd18331342854997150106;
    localparam logic signed [15:0] RST_INNER_KI_Z = 16'sd410;
    localparam logic [15:0]        RST_TICK       = 16'd655;

    // Limits, Q16.16.
    localparam logic signed [39:0] LIM_I32_MIN = -40'sd2147483648;
    localparam logic signed [39:0] LIM_I32_MAX = 40'sd2147483647;
    localparam logic signed [39:0] LIM_POS_I   = 40'sd131072;
    localparam logic signed [39:0] LIM_VEL_I_Y = 40'sd26214;
    localparam logic signed [39:0] LIM_VEL_I_Z = 40'sd13107;
    localparam logic signed [39:0] LIM_ANGLE   = 40'sd13107;
    localparam logic signed [39:0] THRUST_BASE = 40'sd13107;
    localparam logic signed [39:0] THRUST_MAX  = 40'sd62259;
    localparam logic signed [39:0] THRUST_MIN  = 40'sd655;

    typedef enum logic [2:0] {
        CFG_TARGET_X    = 3'd0,
        CFG_TARGET_Y    = 3'd1,
        CFG_TARGET_Z    = 3'd2,
        CFG_OUTER_GAINS = 3'd3,
        CFG_INNER_GAINS = 3'd4,
        CFG_INNER_KI_Z  = 3'd5,
        CFG_TICK_PERIOD = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DLOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_IPZ, OP_IZ, OP_VX, OP_VY, OP_VZ, OP_IVY, OP_IVZ, OP_KIY,
        OP_KIZ, OP_THR, OP_PIT, OP_ROL, OP_QW, OP_QX, OP_QY, OP_QZ
    } t_op;

    function automatic logic signed [39:0] clamp40(input logic signed [39:0] v,
                                                   input logic signed [39:0] lo,
                                                   input logic signed [39:0] hi);
        logic signed [39:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // Table entry k: {cos, sin} of half the angle k*0.2/TRIG_LAST, both Q2.14.
    function automatic logic [31:0] trig_entry(input int k);
        longint unsigned h, h2, h3, h4, h5, sv, cv, sq, cq;
        h  = (64'(k) * 64'd13107 * 64'd32768 + 64'(TRIG_LAST / 2)) / 64'(TRIG_LAST);
        h2 = (h * h) >> 32;
        h3 = (h2 * h) >> 32;
        h4 = (h2 * h2) >> 32;
        h5 = (h4 * h) >> 32;
        sv = h - h3 / 64'd6 + h5 / 64'd120;
        cv = (64'd1 << 32) - h2 / 64'd2 + h4 / 64'd24;
        sq = (sv + (64'd1 << 17)) >> 18;
        cq = (cv + (64'd1 << 17)) >> 18;
        return {cq[15:0], sq[15:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cpvp_serial_mul.sv
// Signed multiplier that consumes the multiplier operand one 4-bit digit per cycle.
`default_nettype none

module cpvp_serial_mul
    import cpvp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic                     o_done,
    output logic signed [MUL_PW-1:0] o_p
);

    logic signed [MUL_PW-1:0] r_acc;
    logic signed [MUL_PW-1:0] r_ash;
    logic [MUL_BW-2:0]        r_dig;
    logic                     r_neg;
    logic [MUL_CW-1:0]        r_cnt;
    logic                     r_busy;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_ash  <= MUL_PW'(i_a);
                r_dig  <= i_b[MUL_BW-2:0];
                r_neg  <= i_b[MUL_BW-1];
            end else if (r_busy) begin
                if (r_cnt == MUL_CW'(MUL_NDIG)) begin
                    // Sign digit of the two's complement multiplier has negative weight.
                    if (r_neg) begin
                        r_acc <= r_acc - r_ash;
                    end
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= r_acc + r_ash * $signed({1'b0, r_dig[MUL_DIG-1:0]});
                    r_ash <= r_ash <<< MUL_DIG;
                    r_dig <= r_dig >> MUL_DIG;
                    r_cnt <= r_cnt + MUL_CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without a preceding busy phase");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while still busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= MUL_CW'(MUL_NDIG))) else $error("digit counter overran");

endmodule

`default_nettype wire

FILE: hdl/cascaded_position_velocity_pi_top.sv
// Top level of the cascaded position/velocity PI controller.
//
// One input item per control tick carries the measured position and velocity
// (Q16.16) and the offboard flag; one result item returns the thrust command
// and the attitude quaternion. The outer loop forms a velocity setpoint from
// the position error, the inner loop forms pitch, roll and thrust from the
// velocity error, and pitch and roll are turned into a quaternion through a
// table of half-angle sines and cosines.
// All sixteen products go through one shared multiplier that takes a 4-bit
// digit of its second operand per cycle; each product is issued in S_ISSUE
// and its result is taken over in S_WAIT. The two table lookups each run a
// restoring division for the nearest entry, one quotient bit per cycle.
// An item therefore runs all products and both divisions in turn, and the
// next item is taken only after its result has gone to the output register.
// Synchronous reset restores the register defaults and clears the three
// integrators. The result sits in an output register: while the receiver
// stalls the next item is still accepted and computed, and the controller
// holds its finished result until the output register is free.
// Configuration writes are taken at any clock with the write enable high.
`default_nettype none

module cascaded_position_velocity_pi_top
    import cpvp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // meas_pos_x[31:0], meas_pos_y[63:32], meas_pos_z[95:64], meas_vel_x[127:96],
    // meas_vel_y[159:128], meas_vel_z[191:160], offboard_active[192], zero pad
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,
    // thrust[15:0], quat_w[31:16], quat_x[47:32], quat_y[63:48], quat_z[79:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_wdata
);

    // Configuration registers.
    logic signed [31:0] r_target_x, r_target_y, r_target_z;
    logic [63:0]        r_outer, r_inner;
    logic signed [15:0] r_inner_ki_z;
    logic [15:0]        r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x   <= RST_TARGET_X;
            r_target_y   <= RST_TARGET_Y;
            r_target_z   <= RST_TARGET_Z;
            r_outer      <= RST_OUTER;
            r_inner      <= RST_INNER;
            r_inner_ki_z <= RST_INNER_KI_Z;
            r_tick       <= RST_TICK;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TARGET_X:    r_target_x   <= i_cfg_wdata[31:0];
                CFG_TARGET_Y:    r_target_y   <= i_cfg_wdata[31:0];
                CFG_TARGET_Z:    r_target_z   <= i_cfg_wdata[31:0];
                CFG_OUTER_GAINS: r_outer      <= i_cfg_wdata;
                CFG_INNER_GAINS: r_inner      <= i_cfg_wdata;
                CFG_INNER_KI_Z:  r_inner_ki_z <= i_cfg_wdata[15:0];
                CFG_TICK_PERIOD: r_tick       <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer state, control.
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_dsel, n_dsel;
    logic   r_ovalid, n_ovalid;

    // Working registers.
    logic signed [32:0] r_ex, n_ex, r_ey, n_ey, r_ez, n_ez;
    logic signed [31:0] r_mvx, n_mvx, r_mvy, n_mvy, r_mvz, n_mvz;
    logic               r_active, n_active;
    logic signed [31:0] r_pz, n_pz, r_vy, n_vy, r_vz, n_vz;
    logic signed [18:0] r_iz, n_iz;
    logic signed [32:0] r_evx, n_evx, r_evy, n_evy, r_evz, n_evz;
    logic signed [15:0] r_ivy, n_ivy;
    logic signed [14:0] r_ivz, n_ivz;
    logic [15:0]        r_thrust, n_thrust;
    logic signed [14:0] r_pitch, n_pitch, r_roll, n_roll;
    logic signed [15:0] r_sp, n_sp, r_cp, n_cp, r_st, n_st, r_ct, n_ct;
    logic [15:0]        r_qw, n_qw, r_qx, n_qx, r_qy, n_qy, r_qz, n_qz;
    logic [TRIG_NW-1:0] r_dnum, n_dnum;
    logic [TRIG_KW-1:0] r_dq, n_dq;
    logic [TRIG_DCW-1:0] r_dcnt, n_dcnt;
    logic [79:0]        r_odata, n_odata;

    // Shared multiplier.
    logic                     w_mul_start;
    logic signed [MUL_AW-1:0] w_mul_a;
    logic signed [MUL_BW-1:0] w_mul_b;
    logic                     w_mul_done;
    logic signed [MUL_PW-1:0] w_mul_p;

    cpvp_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    // Half-angle table, built at elaboration.
    logic [31:0] w_trig [TRIG_DEPTH];
    for (genvar gk = 0; gk < TRIG_DEPTH; gk++) begin : g_trig
        assign w_trig[gk] = trig_entry(gk);
    end

    // Operand selection for the current product.
    always_comb begin
        w_mul_a = r_ez;
        w_mul_b = $signed({1'b0, r_tick});
        case (r_op)
            OP_IPZ: begin w_mul_a = r_ez;        w_mul_b = $signed({1'b0, r_tick}); end
            OP_IZ:  begin w_mul_a = 33'(r_pz);   w_mul_b = 17'($signed(r_outer[63:48])); end
            OP_VX:  begin w_mul_a = r_ex;        w_mul_b = 17'($signed(r_outer[15:0])); end
            OP_VY:  begin w_mul_a = r_ey;        w_mul_b = 17'($signed(r_outer[31:16])); end
            OP_VZ:  begin w_mul_a = r_ez;        w_mul_b = 17'($signed(r_outer[47:32])); end
            OP_IVY: begin w_mul_a = r_evy;       w_mul_b = $signed({1'b0, r_tick}); end
            OP_IVZ: begin w_mul_a = r_evz;       w_mul_b = $signed({1'b0, r_tick}); end
            OP_KIY: begin w_mul_a = 33'(r_vy);   w_mul_b = 17'($signed(r_inner[63:48])); end
            OP_KIZ: begin w_mul_a = 33'(r_vz);   w_mul_b = 17'(r_inner_ki_z); end
            OP_THR: begin w_mul_a = r_evz;       w_mul_b = 17'($signed(r_inner[47:32])); end
            OP_PIT: begin w_mul_a = r_evx;       w_mul_b = 17'($signed(r_inner[15:0])); end
            OP_ROL: begin w_mul_a = r_evy;       w_mul_b = 17'($signed(r_inner[31:16])); end
            OP_QW:  begin w_mul_a = 33'(r_cp);   w_mul_b = 17'(r_ct); end
            OP_QX:  begin w_mul_a = 33'(r_sp);   w_mul_b = 17'(r_ct); end
            OP_QY:  begin w_mul_a = 33'(r_cp);   w_mul_b = 17'(r_st); end
            OP_QZ:  begin w_mul_a = 33'(r_sp);   w_mul_b = 17'(r_st); end
            default: ;
        endcase
    end

    // Product scaled by a Q4.12 gain, and by the Q0.16 tick period.
    logic signed [39:0] w_p12, w_p16, w_vs, w_tmp;
    logic signed [MUL_PW-1:0] w_pq;
    assign w_p12 = 40'($signed(w_mul_p[MUL_PW-1:12]));
    assign w_p16 = 40'($signed(w_mul_p[MUL_PW-1:16]));
    assign w_pq  = w_mul_p + MUL_PW'(8192);

    // Nearest-entry search.
    logic signed [14:0] w_ang;
    logic [13:0]        w_mag;
    logic [TRIG_KW-1:0] w_trial, w_k;
    logic [15:0]        w_sin;
    logic [31:0]        w_ent;

    assign w_ang   = r_dsel ? r_pitch : r_roll;
    assign w_mag   = w_ang[14] ? 14'(-w_ang) : w_ang[13:0];
    assign w_trial = r_dq | (TRIG_KW'(1) << r_dcnt);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_dsel   = r_dsel;
        n_ovalid = r_ovalid;
        n_ex = r_ex; n_ey = r_ey; n_ez = r_ez;
        n_mvx = r_mvx; n_mvy = r_mvy; n_mvz = r_mvz;
        n_active = r_active;
        n_pz = r_pz; n_vy = r_vy; n_vz = r_vz;
        n_iz = r_iz;
        n_evx = r_evx; n_evy = r_evy; n_evz = r_evz;
        n_ivy = r_ivy; n_ivz = r_ivz;
        n_thrust = r_thrust;
        n_pitch = r_pitch; n_roll = r_roll;
        n_sp = r_sp; n_cp = r_cp; n_st = r_st; n_ct = r_ct;
        n_qw = r_qw; n_qx = r_qx; n_qy = r_qy; n_qz = r_qz;
        n_dnum = r_dnum; n_dq = r_dq; n_dcnt = r_dcnt;
        n_odata = r_odata;
        w_mul_start = 1'b0;
        w_vs  = '0;
        w_tmp = '0;
        w_k   = '0;
        w_ent = '0;
        w_sin = '0;

        if (m_axis_tvalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ex = 33'(r_target_x) - 33'($signed(s_axis_tdata[31:0]));
                    n_ey = 33'(r_target_y) - 33'($signed(s_axis_tdata[63:32]));
                    n_ez = 33'(r_target_z) - 33'($signed(s_axis_tdata[95:64]));
                    n_mvx = s_axis_tdata[127:96];
                    n_mvy = s_axis_tdata[159:128];
                    n_mvz = s_axis_tdata[191:160];
                    n_active = s_axis_tdata[192];
                    // Offboard low: integrators cleared before this tick uses them.
                    if (!s_axis_tdata[192]) begin
                        n_pz = '0;
                        n_vy = '0;
                        n_vz = '0;
                    end
                    n_op    = OP_IPZ;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                w_mul_start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (w_mul_done) begin
                    case (r_op)
                        OP_IPZ: if (r_active) begin
                            n_pz = 32'(clamp40(40'(r_pz) + w_p16, LIM_I32_MIN, LIM_I32_MAX));
                        end
                        OP_IZ: n_iz = 19'(clamp40(w_p12, -LIM_POS_I, LIM_POS_I));
                        OP_VX: begin
                            w_vs  = clamp40(w_p12, LIM_I32_MIN, LIM_I32_MAX);
                            n_evx = 33'(w_vs - 40'(r_mvx));
                        end
                        OP_VY: begin
                            w_vs  = clamp40(w_p12, LIM_I32_MIN, LIM_I32_MAX);
                            n_evy = 33'(w_vs - 40'(r_mvy));
                        end
                        OP_VZ: begin
                            w_vs  = clamp40(w_p12 + 40'(r_iz), LIM_I32_MIN, LIM_I32_MAX);
                            n_evz = 33'(w_vs - 40'(r_mvz));
                        end
                        OP_IVY: if (r_active) begin
                            n_vy = 32'(clamp40(40'(r_vy) + w_p16, LIM_I32_MIN, LIM_I32_MAX));
                        end
                        OP_IVZ: if (r_active) begin
                            n_vz = 32'(clamp40(40'(r_vz) + w_p16, LIM_I32_MIN, LIM_I32_MAX));
                        end
                        OP_KIY: n_ivy = 16'(clamp40(w_p12, -LIM_VEL_I_Y, LIM_VEL_I_Y));
                        OP_KIZ: n_ivz = 15'(clamp40(w_p12, -LIM_VEL_I_Z, LIM_VEL_I_Z));
                        OP_THR: begin
                            w_tmp = THRUST_BASE + w_p12 + 40'(r_ivz);
                            if (w_tmp >= THRUST_MAX) begin
                                w_tmp = THRUST_MAX;
                            end
                            if (w_tmp <= THRUST_MIN) begin
                                w_tmp = '0;
                            end
                            n_thrust = w_tmp[15:0];
                        end
                        OP_PIT: n_pitch = 15'(clamp40(w_p12, -LIM_ANGLE, LIM_ANGLE));
                        OP_ROL: n_roll = 15'(clamp40(w_p12 + 40'(r_ivy), -LIM_ANGLE, LIM_ANGLE));
                        OP_QW: n_qw = w_pq[29:14];
                        OP_QX: n_qx = w_pq[29:14];
                        OP_QY: n_qy = w_pq[29:14];
                        OP_QZ: n_qz = w_pq[29:14];
                        default: ;
                    endcase
                    if (r_op == OP_ROL) begin
                        n_dsel  = 1'b0;
                        n_state = S_DLOAD;
                    end else if (r_op == OP_QZ) begin
                        n_state = S_DONE;
                    end else begin
                        n_op    = t_op'(r_op + 4'd1);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DLOAD: begin
                n_dnum  = TRIG_NW'(w_mag) * TRIG_NW'(TRIG_LAST) + TRIG_NW'(6553);
                n_dq    = '0;
                n_dcnt  = TRIG_DCW'(TRIG_KW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (TRIG_NW'(w_trial) * TRIG_NW'(13107) <= r_dnum) begin
                    n_dq = w_trial;
                end
                if (r_dcnt == '0) begin
                    w_k = (n_dq > TRIG_KW'(TRIG_LAST)) ? TRIG_KW'(TRIG_LAST) : n_dq;
                    w_ent = w_trig[w_k];
                    w_sin = w_ang[14] ? 16'(-w_ent[15:0]) : w_ent[15:0];
                    if (r_dsel) begin
                        n_st    = w_sin;
                        n_ct    = w_ent[31:16];
                        n_op    = OP_QW;
                        n_state = S_ISSUE;
                    end else begin
                        n_sp    = w_sin;
                        n_cp    = w_ent[31:16];
                        n_dsel  = 1'b1;
                        n_state = S_DLOAD;
                    end
                end else begin
                    n_dcnt = r_dcnt - TRIG_DCW'(1);
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = {r_qz, r_qy, r_qx, r_qw, r_thrust};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_IPZ;
            r_dsel   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pz     <= '0;
            r_vy     <= '0;
            r_vz     <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_dsel   <= n_dsel;
            r_ovalid <= n_ovalid;
            r_pz     <= n_pz;
            r_vy     <= n_vy;
            r_vz     <= n_vz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex <= n_ex; r_ey <= n_ey; r_ez <= n_ez;
        r_mvx <= n_mvx; r_mvy <= n_mvy; r_mvz <= n_mvz;
        r_active <= n_active;
        r_iz <= n_iz;
        r_evx <= n_evx; r_evy <= n_evy; r_evz <= n_evz;
        r_ivy <= n_ivy; r_ivz <= n_ivz;
        r_thrust <= n_thrust;
        r_pitch <= n_pitch; r_roll <= n_roll;
        r_sp <= n_sp; r_cp <= n_cp; r_st <= n_st; r_ct <= n_ct;
        r_qw <= n_qw; r_qx <= n_qx; r_qy <= n_qy; r_qz <= n_qz;
        r_dnum <= n_dnum; r_dq <= n_dq; r_dcnt <= n_dcnt;
        r_odata <= n_odata;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

`default_nettype wire

FILE: verif/tb_cascaded_position_velocity_pi_top.sv
// Self-checking testbench of the cascaded position/velocity PI controller.
`default_nettype none

module tb_cascaded_position_velocity_pi_top
    import cpvp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One control tick as it travels on the slave stream.
    typedef struct {
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic signed [31:0] vel_x, vel_y, vel_z;
        logic               offboard;
    } t_tick;

    // One set of actuator commands as it leaves the master stream.
    typedef struct {
        logic [15:0] thrust;
        logic [15:0] qw, qx, qy, qz;
    } t_cmd;

    localparam longint CYCLE_LIMIT = 1_500_000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [63:0]  i_cfg_wdata;

    cascaded_position_velocity_pi_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Shadow copies of the registers and of the three integrators.
    longint sh_target_x, sh_target_y, sh_target_z;
    logic [63:0] sh_outer, sh_inner;
    longint sh_ki_z;
    longint sh_tick;
    longint acc_pos_z, acc_vel_y, acc_vel_z;

    t_tick  pending_ticks[$];
    t_cmd   expected_cmds[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatches;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Wide intermediate values never exceed 64 bits here, so plain longint arithmetic
    // with an arithmetic shift gives the floor division that the block uses.
    function automatic longint lim(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return lim(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint gfield(logic [63:0] g, int i);
        logic signed [15:0] f;
        f = g[16*i +: 16];
        return longint'(f);
    endfunction

    function automatic longint gmul(longint g, longint x);
        return (g * x) >>> 12;
    endfunction

    function automatic longint accumulate(longint acc, longint err);
        return sat32(acc + ((err * sh_tick) >>> 16));
    endfunction

    function automatic longint to_q14(longint unsigned v);
        return longint'((v + (64'd1 << 17)) >> 18);
    endfunction

    // Half-angle sine and cosine from the nearest table entry, Q2.14.
    task automatic half_trig(input longint ang, output longint s, output longint c);
        longint unsigned m, k, h, h2, h3, h4, h5;
        m = (ang < 0) ? -ang : ang;
        k = (m * TRIG_LAST + 6553) / 13107;
        if (k > TRIG_LAST) k = TRIG_LAST;
        h  = (k * 64'd13107 * 64'd32768 + TRIG_LAST / 2) / TRIG_LAST;
        h2 = (h * h) >> 32;
        h3 = (h2 * h) >> 32;
        h4 = (h2 * h2) >> 32;
        h5 = (h4 * h) >> 32;
        s = to_q14(h - h3 / 6 + h5 / 120);
        if (ang < 0) s = -s;
        c = to_q14((64'd1 << 32) - h2 / 2 + h4 / 24);
    endtask

    function automatic logic [15:0] qprod(longint a, longint b);
        longint p;
        p = (a * b + 8192) >>> 14;
        return p[15:0];
    endfunction

    // Runs one control tick through the shadow controller and queues its commands.
    task automatic predict_commands(input t_tick t);
        longint ex, ey, ez, iz, vsx, vsy, vsz, evx, evy, evz, ivy, ivz;
        longint thr, pitch, roll, sr, cr, spi, cpi;
        t_cmd c;
        ex = sh_target_x - longint'(t.pos_x);
        ey = sh_target_y - longint'(t.pos_y);
        ez = sh_target_z - longint'(t.pos_z);
        if (t.offboard) begin
            acc_pos_z = accumulate(acc_pos_z, ez);
        end else begin
            acc_pos_z = 0;
            acc_vel_y = 0;
            acc_vel_z = 0;
        end
        iz  = lim(gmul(gfield(sh_outer, 3), acc_pos_z), -131072, 131072);
        vsx = sat32(gmul(gfield(sh_outer, 0), ex));
        vsy = sat32(gmul(gfield(sh_outer, 1), ey));
        vsz = sat32(gmul(gfield(sh_outer, 2), ez) + iz);
        evx = vsx - longint'(t.vel_x);
        evy = vsy - longint'(t.vel_y);
        evz = vsz - longint'(t.vel_z);
        if (t.offboard) begin
            acc_vel_y = accumulate(acc_vel_y, evy);
            acc_vel_z = accumulate(acc_vel_z, evz);
        end
        ivy = lim(gmul(gfield(sh_inner, 3), acc_vel_y), -26214, 26214);
        ivz = lim(gmul(sh_ki_z, acc_vel_z), -13107, 13107);
        thr = 13107 + gmul(gfield(sh_inner, 2), evz) + ivz;
        if (thr >= 62259) thr = 62259;
        if (thr <= 655) thr = 0;
        pitch = lim(gmul(gfield(sh_inner, 0), evx), -13107, 13107);
        roll  = lim(gmul(gfield(sh_inner, 1), evy) + ivy, -13107, 13107);
        half_trig(roll, sr, cr);
        half_trig(pitch, spi, cpi);
        c.thrust = thr[15:0];
        c.qw = qprod(cr, cpi);
        c.qx = qprod(sr, cpi);
        c.qy = qprod(cr, spi);
        c.qz = qprod(sr, spi);
        expected_cmds.push_back(c);
    endtask

    // Register write on the next rising edge; the shadow copy follows.
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_TARGET_X:    sh_target_x = longint'(signed'(val[31:0]));
            CFG_TARGET_Y:    sh_target_y = longint'(signed'(val[31:0]));
            CFG_TARGET_Z:    sh_target_z = longint'(signed'(val[31:0]));
            CFG_OUTER_GAINS: sh_outer    = val;
            CFG_INNER_GAINS: sh_inner    = val;
            CFG_INNER_KI_Z:  sh_ki_z     = longint'(signed'(val[15:0]));
            CFG_TICK_PERIOD: sh_tick     = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
        endcase
    endfunction

    // Ticks are predicted when queued, which is sound because the driver takes
    // them in order and configuration only changes while everything has drained.
    task automatic queue_tick(input logic [31:0] px, py, pz, vx, vy, vz,
                              input logic ob);
        t_tick t;
        t.pos_x = px; t.pos_y = py; t.pos_z = pz;
        t.vel_x = vx; t.vel_y = vy; t.vel_z = vz;
        t.offboard = ob;
        pending_ticks.push_back(t);
        predict_commands(t);
    endtask

    task automatic queue_random_tick();
        // Offboard stays mostly high so that the integrators can build up.
        queue_tick(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                   ($urandom_range(0, 9) != 0));
    endtask

    // Waits until every queued tick has been sent and answered, then lets
    // the block settle before the registers are touched.
    task automatic drain();
        while (pending_ticks.size() != 0 || expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_gains();
        write_reg(CFG_OUTER_GAINS, {$urandom, $urandom});
        write_reg(CFG_INNER_GAINS, {$urandom, $urandom});
        write_reg(CFG_INNER_KI_Z, 64'($urandom_range(0, 65535)));
        write_reg(CFG_TICK_PERIOD, 64'($urandom_range(0, 65535)));
        write_reg(CFG_TARGET_X, 64'(rnd32()));
        write_reg(CFG_TARGET_Y, 64'(rnd32()));
        write_reg(CFG_TARGET_Z, 64'(rnd32()));
    endtask

    // Slave-side driver: holds valid until the item is taken. The item on
    // the bus stays at the head of the queue until it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_ticks.pop_front());
            if ((s_axis_tvalid && !s_axis_tready)) begin
                // Item still waiting; keep it on the bus.
            end else if (pending_ticks.size() > 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                t_tick t;
                t = pending_ticks[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, t.offboard, t.vel_z, t.vel_y, t.vel_x,
                                  t.pos_z, t.pos_y, t.pos_x};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Master-side monitor and stall generator.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                t_cmd e;
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %h", m_axis_tdata);
                end else begin
                    e = expected_cmds.pop_front();
                    if (m_axis_tdata !== {e.qz, e.qy, e.qx, e.qw, e.thrust}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: thrust/qw/qx/qy/qz expected ",
                                      "%h %h %h %h %h, got %h %h %h %h %h"},
                                     e.thrust, e.qw, e.qx, e.qy, e.qz,
                                     m_axis_tdata[15:0], m_axis_tdata[31:16],
                                     m_axis_tdata[47:32], m_axis_tdata[63:48],
                                     m_axis_tdata[79:64]);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_TARGET_X;
        i_cfg_wdata   = '0;
        cycles        = 0;
        mismatches    = 0;
        send_idle_pct = 6;
        recv_idle_pct = 72;
        sh_target_x = 196608; sh_target_y = 65536; sh_target_z = 131072;
        sh_outer = RST_OUTER; sh_inner = RST_INNER;
        sh_ki_z = 410; sh_tick = 655;
        acc_pos_z = 0; acc_vel_y = 0; acc_vel_z = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset settings: hover near target, the
        // extremes of every field, offboard low clearing, thrust limits.
        queue_tick(32'd196608, 32'd65536, 32'd131072, 0, 0, 0, 1'b1);
        queue_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        queue_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        queue_tick(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        queue_tick(0, 0, 32'h0010_0000, 0, 0, 32'h0010_0000, 1'b1);
        queue_tick(0, 0, 32'hfff0_0000, 0, 0, 32'hfff0_0000, 1'b1);
        queue_tick(32'h0001_0000, 32'hffff_0000, 32'd131072, 32'h0000_8000,
                   32'hffff_8000, 0, 1'b1);
        queue_tick(0, 0, 0, 0, 0, 0, 1'b0);
        for (int i = 0; i < 8; i++) queue_random_tick();
        drain();

        // Extreme settings: largest and most negative gains and targets, zero tick period.
        write_reg(CFG_OUTER_GAINS, 64'h7fff_7fff_7fff_7fff);
        write_reg(CFG_INNER_GAINS, 64'h8000_8000_8000_8000);
        write_reg(CFG_INNER_KI_Z, 64'h8000);
        write_reg(CFG_TICK_PERIOD, 64'd0);
        write_reg(CFG_TARGET_X, 64'h7fff_ffff);
        write_reg(CFG_TARGET_Y, 64'h8000_0000);
        write_reg(CFG_TARGET_Z, 64'h8000_0000);
        for (int i = 0; i < 6; i++) queue_random_tick();
        drain();
        write_reg(CFG_TICK_PERIOD, 64'hffff);
        write_reg(CFG_INNER_KI_Z, 64'h7fff);
        write_reg(CFG_OUTER_GAINS, 64'h8000_8000_8000_8000);
        write_reg(CFG_INNER_GAINS, 64'h7fff_7fff_7fff_7fff);
        for (int i = 0; i < 6; i++) queue_random_tick();
        drain();

        // Random phases, each with fresh settings; the idling mix changes at phases 2 and 4.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle_pct = 72; recv_idle_pct = 6; end
            if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0; end
            random_gains();
            for (int i = 0; i < 90; i++) queue_random_tick();
            drain();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
